@@ rtl/core/m7gs_pkg.sv @@
// shared types, constants and the divider step for the mode 7 ground sampler
// no dependencies; used by every module in rtl/core
package m7gs_pkg;

    // operation codes on the op field
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // item classes decided in the front end
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SKY    = 2'd1;
    localparam logic [1:0] KIND_GROUND = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_CAMERA_X    = 3'd0;
    localparam logic [2:0] REG_CAMERA_Y    = 3'd1;
    localparam logic [2:0] REG_HEADING_COS = 3'd2;
    localparam logic [2:0] REG_HEADING_SIN = 3'd3;
    localparam logic [2:0] REG_ALTITUDE    = 3'd4;

    // configuration reset values
    localparam logic [15:0] CAMERA_X_RESET    = 16'd32768;
    localparam logic [15:0] CAMERA_Y_RESET    = 16'd32768;
    localparam logic [15:0] HEADING_COS_RESET = 16'd16384;
    localparam logic [15:0] HEADING_SIN_RESET = 16'd0;
    localparam logic [14:0] ALTITUDE_RESET    = 15'd7680;

    // horizon and projection constants
    localparam logic [14:0] ALT_OFFSET    = 15'd3072;
    localparam logic [7:0]  HZ_BASE       = 8'd78;
    localparam logic [7:0]  HZ_MAX        = 8'd132;
    localparam logic [7:0]  SCREEN_HEIGHT = 8'd192;
    localparam logic [7:0]  DEPTH_SCALE   = 8'd140;
    localparam logic [22:0] Z_MAX         = 23'd435200;
    // lateral divide: floor(n / 70) via reciprocal floor(2^26 / 70)
    localparam logic [19:0] LAT_RECIP     = 20'd958698;
    localparam int          LAT_SHIFT     = 26;
    localparam logic [7:0]  LAT_DIV       = 8'd70;

    // restoring divider: one quotient bit per stage
    localparam int NUM_W     = 23;
    localparam int DIV_STEPS = NUM_W;

    typedef struct packed {
        logic [15:0] camera_x;
        logic [15:0] camera_y;
        logic [15:0] heading_cos;
        logic [15:0] heading_sin;
        logic [14:0] altitude;
    } cfg_t;

    // classified item handed from front end to back end
    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      addr;
        logic [7:0]       wcolour;
        logic [NUM_W-1:0] num;
        logic [6:0]       den;
        logic [6:0]       kx;
    } item_t;

    // divider stage contents
    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      addr;
        logic [7:0]       wcolour;
        logic [6:0]       kx;
        logic [6:0]       den;
        logic [6:0]       rem;
        logic [NUM_W-1:0] work;
    } div_t;

    // one restoring division step
    function automatic div_t div_step(input div_t d);
        div_t       r;
        logic [7:0] cand;
        r    = d;
        cand = {d.rem, d.work[NUM_W-1]};
        if (cand >= {1'b0, d.den})
        begin
            r.rem  = 7'(cand - {1'b0, d.den});
            r.work = {d.work[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cand[6:0];
            r.work = {d.work[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/m7gs_front.sv @@
// front end: accepts transactions, finds the horizon and classifies each item
// depends on m7gs_pkg
module m7gs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  m7gs_pkg::cfg_t       cfg,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic                 op,
    input  logic [15:0]          texel_address,
    input  logic [7:0]           texel_colour,
    input  logic [7:0]           pixel_x,
    input  logic [7:0]           pixel_y,
    input  logic                 q_full,
    output logic                 q_push,
    output m7gs_pkg::item_t      q_item
);

    logic            valid_reg;
    m7gs_pkg::item_t item_reg;
    m7gs_pkg::item_t item_next;
    logic [16:0]     hz_scaled;
    logic [7:0]      hz_raw;
    logic [7:0]      hz;
    logic [7:0]      dy;
    logic            accept;

    assign item_ready = !valid_reg || !q_full;
    assign accept     = item_valid && item_ready;
    assign q_push     = valid_reg && !q_full;
    assign q_item     = item_reg;

    // horizon row from altitude, clamped
    always_comb
    begin
        hz_scaled = 17'(({2'b00, cfg.altitude} - {2'b00, m7gs_pkg::ALT_OFFSET}) * 17'd3);
        hz_raw    = m7gs_pkg::HZ_BASE + {1'b0, hz_scaled[16:10]};
        if (cfg.altitude < m7gs_pkg::ALT_OFFSET)
            hz = m7gs_pkg::HZ_BASE;
        else if (hz_raw > m7gs_pkg::HZ_MAX)
            hz = m7gs_pkg::HZ_MAX;
        else
            hz = hz_raw;
    end

    // classify and set up the depth divide
    always_comb
    begin
        dy                = pixel_y - hz;
        item_next.addr    = texel_address;
        item_next.wcolour = texel_colour;
        item_next.kx      = {~pixel_x[7], pixel_x[6:1]};
        item_next.num     = '0;
        item_next.den     = 7'd1;
        if (op == m7gs_pkg::OP_WRITE)
            item_next.kind = m7gs_pkg::KIND_WRITE;
        else if (pixel_y >= m7gs_pkg::SCREEN_HEIGHT || pixel_y < hz)
            item_next.kind = m7gs_pkg::KIND_SKY;
        else
        begin
            item_next.kind = m7gs_pkg::KIND_GROUND;
            item_next.num  = m7gs_pkg::NUM_W'(cfg.altitude)
                           * m7gs_pkg::NUM_W'(m7gs_pkg::DEPTH_SCALE);
            item_next.den  = {dy[6:1], 1'b1};
        end
    end

    // holding stage in front of the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (q_push)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

@@ rtl/core/m7gs_queue.sv @@
// two-entry queue of classified items between front end and back end
// depends on m7gs_pkg
module m7gs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  m7gs_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output m7gs_pkg::item_t head
);

    m7gs_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/core/m7gs_divider.sv @@
// pipelined restoring divider for the perspective depth, one bit per stage
// depends on m7gs_pkg
module m7gs_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  m7gs_pkg::item_t  in_item,
    output logic             out_valid,
    output m7gs_pkg::div_t   out_div
);

    m7gs_pkg::div_t                    stage_reg [m7gs_pkg::DIV_STEPS];
    logic [m7gs_pkg::DIV_STEPS-1:0]    valid_reg;
    m7gs_pkg::div_t                    first;

    always_comb
    begin
        first.kind    = in_item.kind;
        first.addr    = in_item.addr;
        first.wcolour = in_item.wcolour;
        first.kx      = in_item.kx;
        first.den     = in_item.den;
        first.rem     = '0;
        first.work    = in_item.num;
    end

    assign out_valid = valid_reg[m7gs_pkg::DIV_STEPS-1];
    assign out_div   = stage_reg[m7gs_pkg::DIV_STEPS-1];

    // valid bits move with the whole back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[m7gs_pkg::DIV_STEPS-2:0], in_valid};
    end

    // quotient stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0] <= m7gs_pkg::div_step(first);
            for (int i = 1; i < m7gs_pkg::DIV_STEPS; i++)
                stage_reg[i] <= m7gs_pkg::div_step(stage_reg[i-1]);
        end
    end

endmodule

@@ rtl/core/m7gs_back.sv @@
// back end: depth clamp, lateral offset, rotation, texture store and result queue
// depends on m7gs_pkg; fed by m7gs_divider
module m7gs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  m7gs_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  m7gs_pkg::div_t  in_div,
    output logic            adv,
    output logic            result_valid,
    input  logic            result_ready,
    output logic            ground,
    output logic [7:0]      colour
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  wcolour;
    } meta_t;

    typedef struct packed {
        logic       ground;
        logic [7:0] colour;
    } res_t;

    // stage valid bits: z, l1, l2, l3, l4, r1, r2, m
    logic [7:0]  valid_reg;

    meta_t       z_meta_reg,  l1_meta_reg, l2_meta_reg, l3_meta_reg;
    meta_t       l4_meta_reg, r1_meta_reg, r2_meta_reg;
    logic [1:0]  m_kind_reg;
    logic [18:0] z_reg, l1_z_reg, l2_z_reg, l3_z_reg, l4_z_reg;
    logic [6:0]  z_kx_reg;
    logic        l1_neg_reg, l2_neg_reg, l3_neg_reg;
    logic [24:0] l1_pmag_reg, l2_pmag_reg;
    logic [44:0] l2_prod_reg;
    logic [18:0] l3_q0_reg;
    logic [7:0]  l3_rem_reg;
    logic [19:0] l4_lat_reg;
    logic [29:0] r1_cz_reg, r1_sl_reg, r1_sz_reg, r1_cl_reg;
    logic [15:0] r2_addr_reg;
    logic [7:0]  rdata_reg;
    logic [7:0]  tex_mem [65536];

    logic [18:0] z_next;
    logic [6:0]  kx_mag;
    logic [18:0] q0;
    logic [24:0] rem_full;
    logic [18:0] q_fix;
    logic [29:0] c_ext, s_ext, z_ext, lat_ext;
    logic [29:0] wx, wy;

    res_t        fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;
    res_t        push_res;

    // the back end moves as one while the result queue has room
    assign adv = (count_reg != 2'd2);

    // combinational pieces of each stage
    always_comb
    begin
        if (in_div.work > m7gs_pkg::Z_MAX)
            z_next = m7gs_pkg::Z_MAX[18:0];
        else
            z_next = in_div.work[18:0];
        kx_mag   = z_kx_reg[6] ? 7'(-z_kx_reg) : z_kx_reg;
        q0       = l2_prod_reg[m7gs_pkg::LAT_SHIFT+18:m7gs_pkg::LAT_SHIFT];
        rem_full = l2_pmag_reg - 25'(q0) * 25'(m7gs_pkg::LAT_DIV);
        q_fix    = l3_q0_reg + ((l3_rem_reg >= m7gs_pkg::LAT_DIV) ? 19'd1 : 19'd0);
        c_ext    = {{14{cfg.heading_cos[15]}}, cfg.heading_cos};
        s_ext    = {{14{cfg.heading_sin[15]}}, cfg.heading_sin};
        z_ext    = {11'd0, l4_z_reg};
        lat_ext  = {{10{l4_lat_reg[19]}}, l4_lat_reg};
        wx       = {cfg.camera_x, 14'd0} + r1_cz_reg - r1_sl_reg;
        wy       = {cfg.camera_y, 14'd0} + r1_sz_reg + r1_cl_reg;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[6:0], in_valid};
    end

    // depth, lateral offset and rotation stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_meta_reg  <= '{kind: in_div.kind, addr: in_div.addr, wcolour: in_div.wcolour};
            z_reg       <= z_next;
            z_kx_reg    <= in_div.kx;

            l1_meta_reg <= z_meta_reg;
            l1_z_reg    <= z_reg;
            l1_neg_reg  <= z_kx_reg[6];
            l1_pmag_reg <= 25'(kx_mag) * 25'(z_reg);

            l2_meta_reg <= l1_meta_reg;
            l2_z_reg    <= l1_z_reg;
            l2_neg_reg  <= l1_neg_reg;
            l2_pmag_reg <= l1_pmag_reg;
            l2_prod_reg <= 45'(l1_pmag_reg) * 45'(m7gs_pkg::LAT_RECIP);

            l3_meta_reg <= l2_meta_reg;
            l3_z_reg    <= l2_z_reg;
            l3_neg_reg  <= l2_neg_reg;
            l3_q0_reg   <= q0;
            l3_rem_reg  <= rem_full[7:0];

            l4_meta_reg <= l3_meta_reg;
            l4_z_reg    <= l3_z_reg;
            l4_lat_reg  <= l3_neg_reg ? 20'(-{1'b0, q_fix}) : {1'b0, q_fix};

            r1_meta_reg <= l4_meta_reg;
            r1_cz_reg   <= c_ext * z_ext;
            r1_sl_reg   <= s_ext * lat_ext;
            r1_sz_reg   <= s_ext * z_ext;
            r1_cl_reg   <= c_ext * lat_ext;

            r2_meta_reg <= r1_meta_reg;
            if (r1_meta_reg.kind == m7gs_pkg::KIND_WRITE)
                r2_addr_reg <= r1_meta_reg.addr;
            else
                r2_addr_reg <= {wy[29:22], wx[29:22]};

            m_kind_reg  <= r2_meta_reg.kind;
        end
    end

    // texture store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (adv && valid_reg[6] && r2_meta_reg.kind == m7gs_pkg::KIND_WRITE)
            tex_mem[r2_addr_reg] <= r2_meta_reg.wcolour;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rdata_reg <= tex_mem[r2_addr_reg];
    end

    // result queue
    always_comb
    begin
        push_res.ground = (m_kind_reg == m7gs_pkg::KIND_GROUND);
        push_res.colour = push_res.ground ? rdata_reg : 8'd0;
    end

    assign push         = adv && valid_reg[7] && (m_kind_reg != m7gs_pkg::KIND_WRITE);
    assign result_valid = (count_reg != 2'd0);
    assign pop          = result_valid && result_ready;
    assign ground       = fifo_reg[rd_ptr_reg].ground;
    assign colour       = fifo_reg[rd_ptr_reg].colour;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_res;
    end

endmodule

@@ rtl/core/mode7_ground_sampler.sv @@
// Perspective floor sampler over a 256x256 terrain colour map.
// Input channel (item_valid/item_ready): op 0 stores texel_colour at
// texel_address and gives no result; op 1 samples screen pixel
// (pixel_x, pixel_y) and gives one result (ground, colour).
// Result channel (result_valid/result_ready) returns results in input order.
// Camera position, heading and altitude sit on the APB port at byte
// addresses 0, 4, 8, 12 and 16; write them only while the block is idle.
// Throughput: one transaction per clock in steady state with no result stall.
// On its way to the result an item passes the 23-stage depth divider, the
// lateral divide and rotate stages and the registered texture read.
// The front end holds one item and a two-entry queue; the back end moves as
// one and halts when its two-entry result queue is full, so a stalled
// receiver backs the pipeline up until item_ready falls.
// Reset (rst_n low, asynchronous) empties every stage and queue and loads the
// default camera; the texture store is not cleared and must be written before
// it is sampled.
// depends on m7gs_pkg, m7gs_front, m7gs_queue, m7gs_divider, m7gs_back
module mode7_ground_sampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        op,
    input  logic [15:0] texel_address,
    input  logic [7:0]  texel_colour,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        ground,
    output logic [7:0]  colour,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    m7gs_pkg::cfg_t  cfg_reg;
    logic            cfg_write;
    logic            q_full, q_empty, q_push, q_pop;
    m7gs_pkg::item_t q_in, q_head;
    logic            adv;
    logic            div_valid;
    m7gs_pkg::div_t  div_out;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_x    <= m7gs_pkg::CAMERA_X_RESET;
            cfg_reg.camera_y    <= m7gs_pkg::CAMERA_Y_RESET;
            cfg_reg.heading_cos <= m7gs_pkg::HEADING_COS_RESET;
            cfg_reg.heading_sin <= m7gs_pkg::HEADING_SIN_RESET;
            cfg_reg.altitude    <= m7gs_pkg::ALTITUDE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                m7gs_pkg::REG_CAMERA_X:    cfg_reg.camera_x    <= pwdata[15:0];
                m7gs_pkg::REG_CAMERA_Y:    cfg_reg.camera_y    <= pwdata[15:0];
                m7gs_pkg::REG_HEADING_COS: cfg_reg.heading_cos <= pwdata[15:0];
                m7gs_pkg::REG_HEADING_SIN: cfg_reg.heading_sin <= pwdata[15:0];
                m7gs_pkg::REG_ALTITUDE:    cfg_reg.altitude    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[4:2])
            m7gs_pkg::REG_CAMERA_X:    prdata = {16'd0, cfg_reg.camera_x};
            m7gs_pkg::REG_CAMERA_Y:    prdata = {16'd0, cfg_reg.camera_y};
            m7gs_pkg::REG_HEADING_COS: prdata = {16'd0, cfg_reg.heading_cos};
            m7gs_pkg::REG_HEADING_SIN: prdata = {16'd0, cfg_reg.heading_sin};
            m7gs_pkg::REG_ALTITUDE:    prdata = {17'd0, cfg_reg.altitude};
            default:                   prdata = 32'd0;
        endcase
    end

    // front end
    m7gs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .op            (op),
        .texel_address (texel_address),
        .texel_colour  (texel_colour),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    // decoupling queue
    assign q_pop = adv && !q_empty;

    m7gs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // back end
    m7gs_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (q_pop),
        .in_item   (q_head),
        .out_valid (div_valid),
        .out_div   (div_out)
    );

    m7gs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (div_valid),
        .in_div       (div_out),
        .adv          (adv),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ground       (ground),
        .colour       (colour)
    );

`ifndef SYNTH
    // sky results carry no colour
    a_sky_colour: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ground |-> colour == 8'd0)
        else $error("sky result with non-zero colour");

    // an altitude write lands in the register
    a_alt_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && paddr[4:2] == m7gs_pkg::REG_ALTITUDE
        |=> cfg_reg.altitude == $past(pwdata[14:0]))
        else $error("altitude register not updated");

    // the front end only stalls while the queue is full
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> q_full)
        else $error("input stalled with room in the queue");
`endif

endmodule
